>>> src/hktr_pkg.sv
// Shared types and constants for the hall key rapid trigger core.
`timescale 1ns / 1ps

package hktr_pkg;

  localparam int unsigned SAMPLE_W   = 8;
  localparam int unsigned LEVEL_W    = 7;
  localparam int unsigned NUM_W      = 15;  // (sample - lowest) * 100
  localparam int unsigned DIV_STEPS  = 7;   // quotient never exceeds 100
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [SAMPLE_W-1:0] LOWEST_RST   = 8'hFF;
  localparam logic [SAMPLE_W-1:0] HIGHEST_RST  = 8'd90;
  localparam logic [LEVEL_W-1:0]  PERCENT_FULL = 7'd100;

  localparam logic               RT_ON_RST     = 1'b1;
  localparam logic [LEVEL_W-1:0] PRESS_THR_RST = 7'd50;
  localparam logic [LEVEL_W-1:0] MIN_LVL_RST   = 7'd10;
  localparam logic [LEVEL_W-1:0] MAX_LVL_RST   = 7'd90;
  localparam logic [LEVEL_W-1:0] DELTA_RST     = 7'd10;

  typedef enum logic [2:0] {
    REG_RT_ON     = 3'd0,
    REG_PRESS_THR = 3'd1,
    REG_MIN_LVL   = 3'd2,
    REG_MAX_LVL   = 3'd3,
    REG_DELTA     = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic               rt_on;
    logic [LEVEL_W-1:0] press_thr;
    logic [LEVEL_W-1:0] min_lvl;
    logic [LEVEL_W-1:0] max_lvl;
    logic [LEVEL_W-1:0] delta;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] lowest;
    logic [SAMPLE_W-1:0] highest;
    logic                down;
    logic [LEVEL_W-1:0]  press_lvl;
    logic [LEVEL_W-1:0]  release_lvl;
  } key_state_t;

  localparam key_state_t KEY_STATE_RST = '{
    lowest:      LOWEST_RST,
    highest:     HIGHEST_RST,
    down:        1'b0,
    press_lvl:   PRESS_THR_RST,
    release_lvl: MIN_LVL_RST
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALIB,
    ST_DIV,
    ST_LEVEL,
    ST_FINISH
  } ctrl_state_e;

endpackage

>>> src/hktr_cfg_regs.sv
// APB register file holding the trigger settings.
`timescale 1ns / 1ps

module hktr_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [hktr_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [hktr_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [hktr_pkg::APB_DATA_W-1:0]     prdata,
  output hktr_pkg::cfg_t                      cfg_o
);

  hktr_pkg::cfg_t     cfg_q, cfg_d;
  hktr_pkg::reg_idx_e reg_idx;
  logic               wr_en;

  assign reg_idx = hktr_pkg::reg_idx_e'(paddr[hktr_pkg::APB_ADDR_W-1:2]);
  assign wr_en   = psel & penable & pwrite;  // pready is tied high

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        hktr_pkg::REG_RT_ON:     cfg_d.rt_on     = pwdata[0];
        hktr_pkg::REG_PRESS_THR: cfg_d.press_thr = pwdata[hktr_pkg::LEVEL_W-1:0];
        hktr_pkg::REG_MIN_LVL:   cfg_d.min_lvl   = pwdata[hktr_pkg::LEVEL_W-1:0];
        hktr_pkg::REG_MAX_LVL:   cfg_d.max_lvl   = pwdata[hktr_pkg::LEVEL_W-1:0];
        hktr_pkg::REG_DELTA:     cfg_d.delta     = pwdata[hktr_pkg::LEVEL_W-1:0];
        default:                 cfg_d           = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      hktr_pkg::REG_RT_ON:     prdata = {31'd0, cfg_q.rt_on};
      hktr_pkg::REG_PRESS_THR: prdata = {25'd0, cfg_q.press_thr};
      hktr_pkg::REG_MIN_LVL:   prdata = {25'd0, cfg_q.min_lvl};
      hktr_pkg::REG_MAX_LVL:   prdata = {25'd0, cfg_q.max_lvl};
      hktr_pkg::REG_DELTA:     prdata = {25'd0, cfg_q.delta};
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rt_on     <= hktr_pkg::RT_ON_RST;
      cfg_q.press_thr <= hktr_pkg::PRESS_THR_RST;
      cfg_q.min_lvl   <= hktr_pkg::MIN_LVL_RST;
      cfg_q.max_lvl   <= hktr_pkg::MAX_LVL_RST;
      cfg_q.delta     <= hktr_pkg::DELTA_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/hktr_state_mem.sv
// Per-key state memory with registered read and per-entry valid bits.
`timescale 1ns / 1ps

module hktr_state_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IDX_W = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rd_en_i,
  input  logic [IDX_W-1:0]     rd_idx_i,
  output hktr_pkg::key_state_t rd_state_o,
  input  logic                 wr_en_i,
  input  logic [IDX_W-1:0]     wr_idx_i,
  input  hktr_pkg::key_state_t wr_state_i
);

  hktr_pkg::key_state_t mem [DEPTH];
  hktr_pkg::key_state_t rdata_q;
  logic [DEPTH-1:0]     valid_q;
  logic                 rvalid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_state_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_idx_i];
    end
  end

  // Valid bits stand in for a clearing pass: unwritten keys read as reset state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_idx_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvalid_q <= valid_q[rd_idx_i];
      end
    end
  end

  assign rd_state_o = rvalid_q ? rdata_q : hktr_pkg::KEY_STATE_RST;

endmodule

>>> src/hktr_div.sv
// Restoring divider, one quotient bit per cycle, for the travel mapping.
`timescale 1ns / 1ps

module hktr_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [hktr_pkg::NUM_W-1:0]        num_i,
  input  logic [hktr_pkg::SAMPLE_W-1:0]     den_i,
  output logic                              done_o,
  output logic [hktr_pkg::DIV_STEPS-1:0]    quot_o
);

  localparam int unsigned Q_W = hktr_pkg::DIV_STEPS;
  localparam int unsigned D_W = hktr_pkg::SAMPLE_W;
  localparam logic [2:0]  LAST_STEP = 3'(hktr_pkg::DIV_STEPS - 1);

  logic           busy_q, done_q;
  logic [2:0]     cnt_q;
  logic [D_W-1:0] rem_q, den_q;
  logic [Q_W-1:0] bits_q, quot_q;
  logic [D_W:0]   trial, trial_sub;
  logic           ge;

  // The quotient fits Q_W bits, so the top bits of the numerator are already
  // below the divisor and seed the remainder directly.
  assign trial     = {rem_q, bits_q[Q_W-1]};
  assign ge        = trial >= {1'b0, den_q};
  assign trial_sub = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i[hktr_pkg::NUM_W-1:Q_W];
      bits_q <= num_i[Q_W-1:0];
      den_q  <= den_i;
    end else if (busy_q) begin
      rem_q  <= ge ? trial_sub[D_W-1:0] : trial[D_W-1:0];
      bits_q <= {bits_q[Q_W-2:0], 1'b0};
      quot_q <= {quot_q[Q_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

>>> src/hall_key_rapid_trigger_core.sv
// Top level: hall key travel mapping and rapid trigger evaluation.
//
//  Channel   Dir  Signals                         Beat contents
//  s_axis    in   tvalid/tready/tdata[15:0]       key_row, key_col, sample
//  m_axis    out  tvalid/tready/tdata[7:0]        pressed, travel_percent
//  apb       in   psel/penable/pwrite/paddr/...   trigger settings, 5 registers
//
// Sequence: a key passes CALIB, DIV, LEVEL and FINISH from accept to the next
// accept; the 7-step divider is the longest part. Zero span skips the divider
// (lowest == highest). An out-of-matrix key skips to FINISH and touches no state.
// Reset: per-key state reads as its reset value via valid bits, no sweep.
// Stalls: the result sits in an output register; the core holds its last
// step only while that register is still full.
`timescale 1ns / 1ps

module hall_key_rapid_trigger_core #(
  parameter int unsigned NUM_ROWS = 4,
  parameter int unsigned NUM_COLS = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // slave stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [15:0]                         s_axis_tdata,  // key_row[1:0], key_col[3:2], sample[11:4]
  // master stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [7:0]                          m_axis_tdata,  // pressed[0], travel_percent[7:1]
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [hktr_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [hktr_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [hktr_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int unsigned KEY_COUNT = NUM_ROWS * NUM_COLS;
  localparam int unsigned IDX_W     = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int unsigned SW        = hktr_pkg::SAMPLE_W;
  localparam int unsigned LW        = hktr_pkg::LEVEL_W;

  hktr_pkg::cfg_t        cfg;
  hktr_pkg::ctrl_state_e state_q, state_d;

  // input beat fields
  logic [1:0]    in_row, in_col;
  logic [SW-1:0] in_sample;
  logic          in_range;
  logic [8:0]    key_num;
  logic          accept;

  // control strobes
  logic rd_en, div_start, wr_en, out_load, out_free;

  // item registers
  logic [IDX_W-1:0]     idx_q;
  logic [SW-1:0]        sample_q;
  logic                 in_range_q;
  hktr_pkg::key_state_t key_q, lvl_q, lvl_d, fin, rd_state;
  hktr_pkg::key_state_t cal_state;
  logic [LW-1:0]        travel_q;

  // calibration
  logic [SW-1:0]              hi_new, lo_new, diff, span;
  logic [hktr_pkg::NUM_W-1:0] num;
  logic                       span_zero;

  // divider
  logic          div_done;
  logic [LW-1:0] quot;

  // level arithmetic
  logic [LW-1:0] p_lvl, r_lvl;
  logic [LW:0]   floor_sum, ceil_sum;
  logic [LW-1:0] p_minus_d;

  // output register
  logic          m_valid_q, m_valid_d;
  logic          m_pressed_q, pressed_d;
  logic [LW-1:0] m_travel_q, travel_d;

  assign pready = 1'b1;

  hktr_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  // ---------------- input decode ----------------
  assign in_row    = s_axis_tdata[1:0];
  assign in_col    = s_axis_tdata[3:2];
  assign in_sample = s_axis_tdata[11:4];
  assign in_range  = (5'(in_row) < 5'(NUM_ROWS)) && (5'(in_col) < 5'(NUM_COLS));
  assign key_num   = 9'(in_row) * 9'(NUM_COLS) + 9'(in_col);
  assign accept    = s_axis_tvalid & s_axis_tready;

  // ---------------- state memory ----------------
  hktr_state_mem #(
    .DEPTH (KEY_COUNT),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_idx_i   (key_num[IDX_W-1:0]),
    .rd_state_o (rd_state),
    .wr_en_i    (wr_en),
    .wr_idx_i   (idx_q),
    .wr_state_i (fin)
  );

  // ---------------- calibration (memory data present in CALIB) ----------------
  assign hi_new    = (sample_q > rd_state.highest) ? sample_q : rd_state.highest;
  assign lo_new    = (sample_q < rd_state.lowest) ? sample_q : rd_state.lowest;
  assign diff      = sample_q - lo_new;
  assign span      = hi_new - lo_new;
  assign span_zero = (span == '0);
  assign num       = 15'(diff) * 15'(hktr_pkg::PERCENT_FULL);

  // stored key with the new extremes folded in
  always_comb begin
    cal_state         = rd_state;
    cal_state.lowest  = lo_new;
    cal_state.highest = hi_new;
  end

  hktr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (span),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // ---------------- rapid trigger: press rule (LEVEL) ----------------
  assign p_lvl     = (travel_q < cfg.max_lvl) ? travel_q : cfg.max_lvl;
  assign floor_sum = {1'b0, cfg.delta} + {1'b0, cfg.min_lvl};
  assign p_minus_d = p_lvl - cfg.delta;

  always_comb begin
    lvl_d = key_q;
    if (cfg.rt_on && (travel_q >= key_q.press_lvl)) begin
      lvl_d.down      = 1'b1;
      lvl_d.press_lvl = p_lvl;
      // p - delta >= min  <=>  p >= delta + min, no wrap below zero
      lvl_d.release_lvl = ({1'b0, p_lvl} >= floor_sum) ? p_minus_d : cfg.min_lvl;
    end
  end

  // ---------------- rapid trigger: release rule (FINISH) ----------------
  assign r_lvl    = (travel_q > cfg.min_lvl) ? travel_q : cfg.min_lvl;
  assign ceil_sum = {1'b0, r_lvl} + {1'b0, cfg.delta};

  always_comb begin
    fin = lvl_q;
    // release after press: release wins when both levels are crossed
    if (cfg.rt_on && (travel_q <= lvl_q.release_lvl)) begin
      fin.down        = 1'b0;
      fin.release_lvl = r_lvl;
      fin.press_lvl   = (ceil_sum > {1'b0, cfg.max_lvl}) ? cfg.max_lvl : ceil_sum[LW-1:0];
    end
  end

  always_comb begin
    if (!in_range_q) begin
      pressed_d = 1'b0;
      travel_d  = '0;
    end else begin
      pressed_d = cfg.rt_on ? fin.down : (travel_q >= cfg.press_thr);
      travel_d  = travel_q;
    end
  end

  // ---------------- sequencer ----------------
  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hktr_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = in_range ? hktr_pkg::ST_CALIB : hktr_pkg::ST_FINISH;
        end
      end
      hktr_pkg::ST_CALIB: begin
        state_d = span_zero ? hktr_pkg::ST_LEVEL : hktr_pkg::ST_DIV;
      end
      hktr_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = hktr_pkg::ST_LEVEL;
        end
      end
      hktr_pkg::ST_LEVEL: begin
        state_d = hktr_pkg::ST_FINISH;
      end
      hktr_pkg::ST_FINISH: begin
        if (out_free) begin
          state_d = hktr_pkg::ST_IDLE;
        end
      end
      default: state_d = hktr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    rd_en         = 1'b0;
    div_start     = 1'b0;
    wr_en         = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      hktr_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        rd_en         = s_axis_tvalid & in_range;
      end
      hktr_pkg::ST_CALIB: begin
        div_start = !span_zero;
      end
      hktr_pkg::ST_FINISH: begin
        out_load = out_free;
        wr_en    = out_free & in_range_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= hktr_pkg::ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk_i) begin
    if (accept) begin
      idx_q      <= key_num[IDX_W-1:0];
      sample_q   <= in_sample;
      in_range_q <= in_range;
    end
    if (state_q == hktr_pkg::ST_CALIB) begin
      key_q    <= cal_state;
      travel_q <= '0;  // kept when the span is zero
    end
    if ((state_q == hktr_pkg::ST_DIV) && div_done) begin
      travel_q <= quot;
    end
    if (state_q == hktr_pkg::ST_LEVEL) begin
      lvl_q <= lvl_d;
    end
    if (out_load) begin
      m_pressed_q <= pressed_d;
      m_travel_q  <= travel_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {m_travel_q, m_pressed_q};

endmodule
